>>> src/lpwm_pkg.sv
// ----------------------------------------------------------------------------
// lpwm_pkg
// Shared types and constants for the three-channel LED PWM controller.
// ----------------------------------------------------------------------------
package lpwm_pkg;

  localparam int OP_W      = 3;
  localparam int LED_W     = 2;
  localparam int PCT_W     = 8;
  localparam int DUTY_W    = 7;
  localparam int CHAN_MAX  = 8;
  localparam int CH_IDX_W  = 3;

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_TOGGLE = 3'd1;
  localparam logic [OP_W-1:0] OP_PWM    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

  localparam logic [PCT_W-1:0] PCT_LIMIT = 8'd100;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [LED_W-1:0] led;
    logic             level;
    logic [PCT_W-1:0] percent;
  } req_t;

  typedef struct packed {
    logic             go;
    logic             sel;
    logic [OP_W-1:0]  op;
    logic             level;
    logic [PCT_W-1:0] percent;
  } chan_cmd_t;

endpackage

>>> src/lpwm_timebase.sv
// ----------------------------------------------------------------------------
// lpwm_timebase
// Prescaler and shared single-slope PWM period counter.
// ----------------------------------------------------------------------------
module lpwm_timebase import lpwm_pkg::*; #(
  parameter int PRESCALE   = 16,
  parameter int PERIOD_TOP = 99,
  parameter int PS_W       = 4,
  parameter int CNT_W      = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  output logic [CNT_W-1:0] period_nxt
);

  logic [PS_W-1:0]  pre_r;
  logic [PS_W-1:0]  pre_nxt;
  logic [CNT_W-1:0] period_r;

  always_comb begin
    pre_nxt    = pre_r;
    period_nxt = period_r;
    if (tick) begin
      if (pre_r == PS_W'(PRESCALE - 1)) begin
        pre_nxt = '0;
        if (period_r == CNT_W'(PERIOD_TOP)) begin
          period_nxt = '0;
        end else begin
          period_nxt = period_r + CNT_W'(1);
        end
      end else begin
        pre_nxt = pre_r + PS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r    <= '0;
      period_r <= '0;
    end else begin
      pre_r    <= pre_nxt;
      period_r <= period_nxt;
    end
  end

endmodule

>>> src/lpwm_chan.sv
// ----------------------------------------------------------------------------
// lpwm_chan
// One LED channel: mode, output bit and duty, with read and pin logic.
// ----------------------------------------------------------------------------
module lpwm_chan import lpwm_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  chan_cmd_t        cmd,
  input  logic [CNT_W-1:0] period_nxt,
  output logic             lit,
  output logic             pin_nxt
);

  localparam int CMP_W = (CNT_W > DUTY_W) ? CNT_W : DUTY_W;

  logic              mode_r;
  logic              mode_nxt;
  logic              bit_r;
  logic              bit_nxt;
  logic [DUTY_W-1:0] duty_r;
  logic [DUTY_W-1:0] duty_nxt;

  always_comb begin
    mode_nxt = mode_r;
    bit_nxt  = bit_r;
    duty_nxt = duty_r;
    if (cmd.go && cmd.sel) begin
      case (cmd.op)
        OP_WRITE: begin
          mode_nxt = 1'b0;
          bit_nxt  = cmd.level;
        end
        OP_TOGGLE: begin
          mode_nxt = 1'b0;
          bit_nxt  = ~bit_r;
        end
        OP_PWM: begin
          if (cmd.percent <= PCT_LIMIT) begin
            mode_nxt = 1'b1;
            duty_nxt = cmd.percent[DUTY_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign lit     = mode_r ? (duty_r != '0) : bit_r;
  assign pin_nxt = mode_nxt ? (CMP_W'(period_nxt) < CMP_W'(duty_nxt)) : bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      bit_r  <= 1'b0;
      duty_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      bit_r  <= bit_nxt;
      duty_r <= duty_nxt;
    end
  end

endmodule

>>> src/three_channel_led_pwm_controller.sv
// ----------------------------------------------------------------------------
// three_channel_led_pwm_controller
// LED controller with switched and dimmed modes over a shared PWM counter.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up and returns one
// result per request from the output register. A request is held in an
// input register; the channel state, the prescaler and the period counter
// update from it in the same cycle that its result is loaded into the output
// register, so the input and output registers set the rate and latency. The
// pins in each result show the drive levels after that request. Pins of
// channels at or above CHANNELS read 0.
module three_channel_led_pwm_controller import lpwm_pkg::*; #(
  parameter int PRESCALE   = 16,
  parameter int PERIOD_TOP = 99,
  parameter int CHANNELS   = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_op,
  input  logic [LED_W-1:0] in_led,
  input  logic             in_level,
  input  logic [PCT_W-1:0] in_percent,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_read_lit,
  output logic             out_rejected,
  output logic             out_pin_red,
  output logic             out_pin_green,
  output logic             out_pin_blue
);

  localparam int PS_W  = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
  localparam int CNT_W = $clog2(PERIOD_TOP + 1);

  req_t                s1_r;
  logic                s1_valid_r;
  logic                go;
  logic [CNT_W-1:0]    period_nxt;
  logic [CHAN_MAX-1:0] lit_all;
  logic [CHAN_MAX-1:0] pin_all;
  logic [CH_IDX_W-1:0] idx;
  logic                out_valid_r;
  logic                read_lit_r;
  logic                rejected_r;
  logic [2:0]          pins_r;

  assign go       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || go;
  assign idx      = CH_IDX_W'(s1_r.led);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= '{op: in_op, led: in_led, level: in_level, percent: in_percent};
    end
  end

  lpwm_timebase #(
    .PRESCALE   (PRESCALE),
    .PERIOD_TOP (PERIOD_TOP),
    .PS_W       (PS_W),
    .CNT_W      (CNT_W)
  ) u_timebase (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (go && (s1_r.op == OP_TICK)),
    .period_nxt (period_nxt)
  );

  for (genvar g = 0; g < CHAN_MAX; g++) begin : g_chan
    if (g < CHANNELS) begin : g_on
      chan_cmd_t cmd;
      assign cmd = '{go: go, sel: (idx == CH_IDX_W'(g)), op: s1_r.op,
                     level: s1_r.level, percent: s1_r.percent};
      lpwm_chan #(
        .CNT_W (CNT_W)
      ) u_chan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .period_nxt (period_nxt),
        .lit        (lit_all[g]),
        .pin_nxt    (pin_all[g])
      );
    end else begin : g_off
      assign lit_all[g] = 1'b0;
      assign pin_all[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_lit_r <= (s1_r.op == OP_READ) && lit_all[idx];
      rejected_r <= (s1_r.op == OP_PWM) && (s1_r.percent > PCT_LIMIT);
      pins_r     <= pin_all[2:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_lit  = read_lit_r;
  assign out_rejected  = rejected_r;
  assign out_pin_red   = pins_r[0];
  assign out_pin_green = pins_r[1];
  assign out_pin_blue  = pins_r[2];

endmodule

>>> src/lpwm_chk.sv
// ----------------------------------------------------------------------------
// lpwm_chk
// Port-level checks for the LED PWM controller, bound to the top level.
// ----------------------------------------------------------------------------
module lpwm_chk import lpwm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [OP_W-1:0]  in_op,
  input logic [LED_W-1:0] in_led,
  input logic             in_level,
  input logic [PCT_W-1:0] in_percent,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_read_lit,
  input logic             out_rejected,
  input logic             out_pin_red,
  input logic             out_pin_green,
  input logic             out_pin_blue
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while result register empty");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_lit && out_rejected))
    else $error("read and reject flagged together");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_pin_red) && $stable(out_pin_green) && $stable(out_pin_blue))
    else $error("pins changed while result stalled");

endmodule

bind three_channel_led_pwm_controller lpwm_chk u_lpwm_chk (.*);

>>> dv/led_pwm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_pwm_checker
// Watches every channel of the LED PWM controller, runs its own model of the
// channel modes, duty values and prescaled period counter, and compares every
// returned result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module led_pwm_checker import lpwm_pkg::*; #(
  parameter int PRESCALE   = 16,
  parameter int PERIOD_TOP = 99,
  parameter int CHANNELS   = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [OP_W-1:0]  in_op,
  input  logic [LED_W-1:0] in_led,
  input  logic             in_level,
  input  logic [PCT_W-1:0] in_percent,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_read_lit,
  input  logic             out_rejected,
  input  logic             out_pin_red,
  input  logic             out_pin_green,
  input  logic             out_pin_blue,
  output int               mismatches,
  output int               pending,
  output int               requests_seen,
  output int               results_seen
);

  typedef struct packed {
    logic read_lit;
    logic rejected;
    logic pin_red;
    logic pin_green;
    logic pin_blue;
  } led_result_t;

  int unsigned        prescaler;
  int unsigned        period;
  logic               dimmed  [CHANNELS];
  logic               lamp_on [CHANNELS];
  logic [DUTY_W-1:0]  duty    [CHANNELS];
  led_result_t        pending_results [$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    requests_seen = 0;
    results_seen  = 0;
  end

  function automatic logic pin_drive(int ch);
    if (ch >= CHANNELS) return 1'b0;
    if (dimmed[ch]) return (period < duty[ch]);
    return lamp_on[ch];
  endfunction

  function automatic led_result_t apply_led_request(logic [OP_W-1:0]  op,
                                                    logic [LED_W-1:0] led,
                                                    logic             level,
                                                    logic [PCT_W-1:0] pct);
    led_result_t r;
    logic        known;
    r     = '0;
    known = (led < CHANNELS);
    case (op)
      OP_WRITE: begin
        if (known) begin
          dimmed[led]  = 1'b0;
          lamp_on[led] = level;
        end
      end
      OP_TOGGLE: begin
        if (known) begin
          dimmed[led]  = 1'b0;
          lamp_on[led] = ~lamp_on[led];
        end
      end
      OP_PWM: begin
        if (pct > PCT_LIMIT) begin
          r.rejected = 1'b1;
        end else if (known) begin
          duty[led]   = pct[DUTY_W-1:0];
          dimmed[led] = 1'b1;
        end
      end
      OP_READ: begin
        if (known) r.read_lit = dimmed[led] ? (duty[led] != '0) : lamp_on[led];
      end
      OP_TICK: begin
        prescaler++;
        if (prescaler >= PRESCALE) begin
          prescaler = 0;
          if (period >= PERIOD_TOP) period = 0;
          else period++;
        end
      end
      default: ;
    endcase
    r.pin_red   = pin_drive(0);
    r.pin_green = pin_drive(1);
    r.pin_blue  = pin_drive(2);
    return r;
  endfunction

  always @(posedge clk) begin
    led_result_t got;
    led_result_t want;
    if (!rst_n) begin
      prescaler = 0;
      period    = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        dimmed[i]  = 1'b0;
        lamp_on[i] = 1'b0;
        duty[i]    = '0;
      end
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_read_lit, out_rejected, out_pin_red, out_pin_green, out_pin_blue};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: %b", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got.read_lit !== want.read_lit || got.rejected !== want.rejected ||
              got.pin_red !== want.pin_red || got.pin_green !== want.pin_green ||
              got.pin_blue !== want.pin_blue) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch read_lit %b/%b rejected %b/%b rgb %b%b%b/%b%b%b (exp/act)",
                       $time, want.read_lit, got.read_lit, want.rejected, got.rejected,
                       want.pin_red, want.pin_green, want.pin_blue,
                       got.pin_red, got.pin_green, got.pin_blue);
          end
        end
      end
      if (in_valid && in_ready) begin
        requests_seen++;
        pending_results.push_back(apply_led_request(in_op, in_led, in_level, in_percent));
      end
    end
    pending = pending_results.size();
  end

endmodule

>>> dv/tb_three_channel_led_pwm_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_channel_led_pwm_controller
// Drives directed and random LED requests into the controller under random
// idling on both sides, with a long output hold-off and full drains, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_three_channel_led_pwm_controller;
  import lpwm_pkg::*;

  localparam int LED_PRESCALE = 16;
  localparam int LED_TOP      = 99;
  localparam int LED_CHANNELS = 3;
  localparam int RANDOM_REQS  = 980;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  in_op         = OP_WRITE;
  logic [LED_W-1:0] in_led        = '0;
  logic             in_level      = 1'b0;
  logic [PCT_W-1:0] in_percent    = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic             out_read_lit;
  logic             out_rejected;
  logic             out_pin_red;
  logic             out_pin_green;
  logic             out_pin_blue;

  int mismatches;
  int pending;
  int requests_seen;
  int results_seen;
  int quiet_cycles = 0;
  int tick_reqs    = 0;
  int pwm_reqs     = 0;
  bit in_took      = 1'b0;
  bit steady       = 1'b0;
  bit stall_rx     = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  three_channel_led_pwm_controller #(
    .PRESCALE  (LED_PRESCALE),
    .PERIOD_TOP(LED_TOP),
    .CHANNELS  (LED_CHANNELS)
  ) dut (.*);

  led_pwm_checker #(
    .PRESCALE  (LED_PRESCALE),
    .PERIOD_TOP(LED_TOP),
    .CHANNELS  (LED_CHANNELS)
  ) checker_i (.*);

  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold off the result side on request, otherwise ready at random, or always while steady
  initial begin
    forever begin
      @(negedge clk);
      if (stall_rx) begin
        stall_rx = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic offer(input req_t r);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= r.op;
    in_led     <= r.led;
    in_level   <= r.level;
    in_percent <= r.percent;
    if (r.op == OP_TICK) tick_reqs++;
    if (r.op == OP_PWM) pwm_reqs++;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick      = $urandom_range(99);
    r.led     = ($urandom_range(9) == 0) ? 2'd3 : LED_W'($urandom_range(2));
    r.level   = 1'($urandom_range(1));
    r.percent = PCT_W'($urandom_range(255));
    if (pick < 80) begin
      r.op = OP_TICK;
    end else if (pick < 88) begin
      r.op = OP_PWM;
      case ($urandom_range(9))
        0:       r.percent = PCT_W'($urandom_range(255, 101));
        1:       r.percent = PCT_LIMIT;
        2:       r.percent = '0;
        default: r.percent = PCT_W'($urandom_range(100));
      endcase
    end else if (pick < 92) begin
      r.op = OP_WRITE;
    end else if (pick < 95) begin
      r.op = OP_TOGGLE;
    end else if (pick < 98) begin
      r.op = OP_READ;
    end else begin
      r.op = OP_W'($urandom_range(2**OP_W - 1, OP_TICK + 1));
    end
    return r;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer('{OP_READ,   2'd0, 1'b0, 8'd0});
    offer('{OP_WRITE,  2'd0, 1'b1, 8'd0});
    offer('{OP_READ,   2'd0, 1'b0, 8'd0});
    offer('{OP_WRITE,  2'd1, 1'b1, 8'd0});
    offer('{OP_TOGGLE, 2'd1, 1'b0, 8'd0});
    offer('{OP_TOGGLE, 2'd2, 1'b0, 8'd0});
    offer('{OP_PWM,    2'd0, 1'b0, PCT_LIMIT});
    offer('{OP_PWM,    2'd1, 1'b0, 8'd0});
    offer('{OP_READ,   2'd1, 1'b0, 8'd0});
    offer('{OP_READ,   2'd0, 1'b0, 8'd0});
    offer('{OP_PWM,    2'd2, 1'b0, 8'd101});
    offer('{OP_PWM,    2'd3, 1'b1, 8'd255});
    offer('{OP_PWM,    2'd3, 1'b0, 8'd50});
    offer('{OP_WRITE,  2'd3, 1'b1, 8'd0});
    offer('{OP_TOGGLE, 2'd3, 1'b0, 8'd0});
    offer('{OP_READ,   2'd3, 1'b0, 8'd0});
    for (int k = OP_TICK + 1; k < 2**OP_W; k++)
      offer('{OP_W'(k), 2'd3, 1'b1, 8'd255});
    offer('{OP_TICK,   2'd0, 1'b0, 8'd0});
    offer('{OP_PWM,    2'd2, 1'b1, 8'd1});
    offer('{OP_READ,   2'd2, 1'b0, 8'd0});
    offer('{OP_WRITE,  2'd0, 1'b0, 8'd0});
    drain();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 200) stall_rx = 1'b1;
      if (n == 400) drain();
      steady = (n >= 500 && n < 700);
      offer(random_request());
    end

    drain();
    repeat (8) @(negedge clk);
    $display("run: %0d requests (%0d clock ticks, %0d pwm settings), %0d results checked",
             requests_seen, tick_reqs, pwm_reqs, results_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lpwm_pkg.sv
src/lpwm_timebase.sv
src/lpwm_chan.sv
src/three_channel_led_pwm_controller.sv
src/lpwm_chk.sv
dv/led_pwm_checker.sv
dv/tb_three_channel_led_pwm_controller.sv
